>>> src/lac_pkg.sv
// ----------------------------------------------------------------------------
// lac_pkg: shared types and constants of the lagged autocorrelation block
// Field widths, register codes, reset values and the controller/datapath
// command and status structs.
// ----------------------------------------------------------------------------
`default_nettype none

package lac_pkg;

  // field and register widths
  localparam int SAMPLE_W  = 16;
  localparam int LAG_W     = 9;
  localparam int MEAN_W    = 24;
  localparam int VAR_W     = 40;
  localparam int CNT_W     = 24;
  localparam int RES_W     = 16;
  localparam int CFG_IDX_W = 2;

  // arithmetic widths
  localparam int FRAC_W = 8;                    // Q.8 fraction of mean/variance
  localparam int DEV_W  = SAMPLE_W + FRAC_W + 1; // signed deviation
  localparam int PROD_W = 2 * DEV_W;            // deviation product
  localparam int ACC_W  = 64;                   // product sum
  localparam int HALF_W = VAR_W / 2;            // variance split for the divisor
  localparam int QUO_W  = 16;                   // quotient bits developed
  localparam int QFRAC  = 6;                    // extra scale of the sum (x64)
  localparam int REM_W  = ACC_W + QFRAC;
  localparam int DSH_W  = ACC_W + QUO_W - 1;
  localparam int STEP_W = $clog2(QUO_W);

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};

  // register reset values
  localparam logic [LAG_W-1:0]  LAG_RESET  = LAG_W'(1);
  localparam logic [MEAN_W-1:0] MEAN_RESET = '0;
  localparam logic [VAR_W-1:0]  VAR_RESET  = VAR_W'(256);

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LAG  = 2'd0,
    REG_MEAN = 2'd1,
    REG_VAR  = 2'd2
  } cfg_reg_t;

  // controller states
  typedef enum logic [2:0] {
    S_RUN,
    S_DRAIN,
    S_SCALE_LO,
    S_SCALE_HI,
    S_DIV_INIT,
    S_DIV,
    S_FINISH
  } lac_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // sample transfer: write delay line, read partner
    logic mul;       // deviation product stage
    logic acc;       // accumulate stage
    logic scale_lo;  // divisor, low half of variance
    logic scale_hi;  // divisor, high half of variance
    logic div_init;  // load divider
    logic div_step;  // one quotient bit
    logic finish;    // register result, clear run state
  } lac_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_last;  // final quotient bit this cycle
  } lac_stat_t;

endpackage

`default_nettype wire

>>> src/lac_in_if.sv
// ----------------------------------------------------------------------------
// lac_in_if: sample channel
// Valid/ready channel that carries one sample and its end-of-series flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface lac_in_if;
  import lac_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  logic                last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

`default_nettype wire

>>> src/lac_out_if.sv
// ----------------------------------------------------------------------------
// lac_out_if: result channel
// Valid/ready channel that carries one normalized autocorrelation result.
// ----------------------------------------------------------------------------
`default_nettype none

interface lac_out_if;
  import lac_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [RES_W-1:0] autocorrelation;
  logic [CNT_W-1:0]        sample_total;
  logic                    saturated;

  modport source (output valid, output autocorrelation, output sample_total,
                  output saturated, input ready);
  modport sink   (input valid, input autocorrelation, input sample_total,
                  input saturated, output ready);
endinterface

`default_nettype wire

>>> src/lac_datapath.sv
// ----------------------------------------------------------------------------
// lac_datapath: delay line, multiply-accumulate and normalizing divider
// Three-stage sample pipeline (memory read, product, saturating add), then
// a two-step divisor multiply and a bit-serial restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none

module lac_datapath #(
  parameter int MAX_LAG = 512
) (
  input  logic                              clk,
  input  logic                              rst,
  input  lac_pkg::lac_cmd_t                 cmd,
  output lac_pkg::lac_stat_t                stat,
  input  logic [lac_pkg::LAG_W-1:0]         lag_distance,
  input  logic [lac_pkg::MEAN_W-1:0]        mean_value,
  input  logic [lac_pkg::VAR_W-1:0]         variance_value,
  input  logic [lac_pkg::SAMPLE_W-1:0]      sample,
  output logic signed [lac_pkg::RES_W-1:0]  autocorrelation,
  output logic [lac_pkg::CNT_W-1:0]         sample_total,
  output logic                              saturated
);
  import lac_pkg::*;

  localparam int PW = (MAX_LAG > 1) ? $clog2(MAX_LAG) : 1;
  localparam int SW = ((PW > LAG_W) ? PW : LAG_W) + 2;
  localparam logic [SW-1:0] DEPTH = SW'(MAX_LAG);
  localparam logic [PW-1:0] WP_LAST = PW'(MAX_LAG - 1);

  // delay line
  logic [SAMPLE_W-1:0] delay_line [MAX_LAG];
  logic [SAMPLE_W-1:0] rd_data;

  // run state
  logic [PW-1:0]    wp;
  logic [CNT_W-1:0] cnt;
  logic [ACC_W-1:0] psum;
  logic             ovf;

  // pipeline payload
  logic [SAMPLE_W-1:0] s1_x;
  logic                s1_pair;
  logic                s1_self;
  logic [PROD_W-1:0]   prod;
  logic                s2_pair;

  // divider
  logic [ACC_W-1:0]  dprod;
  logic [REM_W-1:0]  rem;
  logic [DSH_W-1:0]  dsh;
  logic [QUO_W-1:0]  quo;
  logic [STEP_W-1:0] step;
  logic              neg;
  logic              mag_zero;

  // partner address: write pointer minus lag, wrapped once
  logic [SW-1:0] rd_sum;
  logic [SW-1:0] rd_wrap;
  logic [PW-1:0] rd_addr;
  logic          pair_now;

  assign rd_sum   = SW'(wp) + DEPTH - SW'(lag_distance);
  assign rd_wrap  = (rd_sum >= DEPTH) ? rd_sum - DEPTH : rd_sum;
  assign rd_addr  = rd_wrap[PW-1:0];
  assign pair_now = (SW'(lag_distance) < DEPTH) && (cnt >= CNT_W'(lag_distance));

  // deviations and their product
  logic [SAMPLE_W-1:0]      old_x;
  logic signed [DEV_W-1:0]  dev_now;
  logic signed [DEV_W-1:0]  dev_old;
  logic signed [PROD_W-1:0] prod_full;

  assign old_x     = s1_self ? s1_x : rd_data;
  assign dev_now   = $signed({1'b0, s1_x, {FRAC_W{1'b0}}}) - $signed({1'b0, mean_value});
  assign dev_old   = $signed({1'b0, old_x, {FRAC_W{1'b0}}}) - $signed({1'b0, mean_value});
  assign prod_full = dev_now * dev_old;

  // saturating add, one guard bit
  logic [ACC_W:0] sum_ext;
  logic           sum_ovf;

  assign sum_ext = {psum[ACC_W-1], psum} +
                   {{(ACC_W+1-PROD_W){prod[PROD_W-1]}}, prod};
  assign sum_ovf = sum_ext[ACC_W] != sum_ext[ACC_W-1];

  // divisor = variance * count, one half of variance per cycle
  logic [HALF_W-1:0]       scale_a;
  logic [HALF_W+CNT_W-1:0] scale_p;

  assign scale_a = cmd.scale_hi ? variance_value[VAR_W-1:HALF_W]
                                : variance_value[HALF_W-1:0];
  assign scale_p = scale_a * cnt;

  // magnitude of the sum
  logic [ACC_W-1:0] mag;
  assign mag = psum[ACC_W-1] ? (~psum + ACC_W'(1)) : psum;

  // one restoring step
  logic div_ge;
  assign div_ge = {{(DSH_W-REM_W){1'b0}}, rem} >= dsh;

  assign stat.div_last = (step == STEP_W'(QUO_W - 1));

  // result selection; a zero divisor sets every quotient bit
  logic [RES_W-1:0] res_val;
  logic             res_sat;

  always_comb begin
    if (mag_zero) begin
      res_val = '0;
      res_sat = ovf;
    end else if (quo[QUO_W-1]) begin
      res_val = neg ? RES_MIN : RES_MAX;
      res_sat = 1'b1;
    end else begin
      res_val = neg ? (~RES_W'(quo) + RES_W'(1)) : RES_W'(quo);
      res_sat = ovf;
    end
  end

  // memory and payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      delay_line[wp] <= sample;
      rd_data        <= delay_line[rd_addr];
      s1_x           <= sample;
      s1_pair        <= pair_now;
      s1_self        <= (lag_distance == '0);
    end
    if (cmd.mul) begin
      prod    <= prod_full;
      s2_pair <= s1_pair;
    end
    if (cmd.scale_lo) begin
      dprod <= {{HALF_W{1'b0}}, scale_p};
    end
    if (cmd.scale_hi) begin
      dprod <= dprod + {scale_p, {HALF_W{1'b0}}};
    end
    if (cmd.div_init) begin
      neg      <= psum[ACC_W-1];
      mag_zero <= (psum == '0);
      rem      <= {mag, {QFRAC{1'b0}}};
      dsh      <= {dprod, {(QUO_W-1){1'b0}}};
      quo      <= '0;
    end
    if (cmd.div_step) begin
      if (div_ge) begin
        rem <= rem - dsh[REM_W-1:0];
      end
      quo <= {quo[QUO_W-2:0], div_ge};
      dsh <= dsh >> 1;
    end
    if (cmd.finish) begin
      autocorrelation <= res_val;
      sample_total    <= cnt;
      saturated       <= res_sat;
    end
  end

  // run state and divider step count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      cnt  <= '0;
      psum <= '0;
      ovf  <= 1'b0;
      step <= '0;
    end else begin
      if (cmd.load) begin
        wp <= (wp == WP_LAST) ? '0 : wp + PW'(1);
        if (cnt != CNT_MAX) begin
          cnt <= cnt + CNT_W'(1);
        end
      end
      if (cmd.acc && s2_pair) begin
        if (sum_ovf) begin
          psum <= sum_ext[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
          psum <= sum_ext[ACC_W-1:0];
        end
      end
      // counter stuck at full or sum clamped
      if ((cmd.load && cnt == CNT_MAX) || (cmd.acc && s2_pair && sum_ovf)) begin
        ovf <= 1'b1;
      end
      if (cmd.div_init) begin
        step <= '0;
      end else if (cmd.div_step) begin
        step <= step + STEP_W'(1);
      end
      if (cmd.finish) begin
        wp   <= '0;
        cnt  <= '0;
        psum <= '0;
        ovf  <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> src/lac_ctrl.sv
// ----------------------------------------------------------------------------
// lac_ctrl: sequencer of the lagged autocorrelation block
// Tracks the sample pipeline, stops intake after the end of a series,
// runs divisor multiply and divider, and owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module lac_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               feed_valid,
  input  logic               feed_last,
  output logic               feed_ready,
  input  logic               res_ready,
  output logic               res_valid,
  output lac_pkg::lac_cmd_t  cmd,
  input  lac_pkg::lac_stat_t stat
);
  import lac_pkg::*;

  lac_state_t state, state_next;
  logic       v1, v2;
  logic       load;
  logic       slot_free;

  // state and pipeline valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_RUN;
      v1        <= 1'b0;
      v2        <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      v1    <= load;
      v2    <= v1;
      if (cmd.finish) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  assign slot_free = !res_valid || res_ready;

  // next state and commands; no intake while in reset
  always_comb begin
    state_next   = state;
    feed_ready   = (state == S_RUN) && !rst;
    load         = feed_valid && feed_ready;
    cmd          = '0;
    cmd.load     = load;
    cmd.mul      = v1;
    cmd.acc      = v2;
    unique case (state)
      S_RUN: begin
        if (load && feed_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // last sample is in the accumulate stage
        if (v2 && !v1) begin
          state_next = S_SCALE_LO;
        end
      end
      S_SCALE_LO: begin
        cmd.scale_lo = 1'b1;
        state_next   = S_SCALE_HI;
      end
      S_SCALE_HI: begin
        cmd.scale_hi = 1'b1;
        state_next   = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          cmd.finish = 1'b1;
          state_next = S_RUN;
        end
      end
      default: begin
        state_next = S_RUN;
      end
    endcase
  end

`ifndef SYNTH
  // intake stops right after the end of a series
  a_last_blocks: assert property (@(posedge clk) disable iff (rst)
    (load && feed_last) |=> !feed_ready)
    else $error("sample taken after end of series");

  // a result only appears out of the finish step
  a_valid_src: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state == S_FINISH))
    else $error("result valid without finish");

  // pipeline is empty while dividing
  a_div_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (!v1 && !v2 && !load))
    else $error("sample in flight during divide");

  // finish presents the result and reopens intake
  a_finish: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (res_valid && feed_ready))
    else $error("finish did not present result");
`endif

endmodule

`default_nettype wire

>>> src/lagged_autocorrelation.sv
// ----------------------------------------------------------------------------
// lagged_autocorrelation: sample autocorrelation at a configured lag
// Samples arrive on the feed channel (sample, last). The block pairs each
// sample with the one lag_distance samples earlier, once the run holds that
// many, and sums (x[n]-mean)*(x[n-lag]-mean) in a saturating accumulator.
// The sample flagged last yields one transfer on the result channel:
// sum*64/(variance*n) as saturated Q1.14, the sample count and a flag.
// Throughput: one sample per cycle while feed.ready is high, through a delay
// line with one write and one read port and the three-stage pipeline.
// After the last sample, the result passes the rest of the pipeline, the two-step
// divisor multiply, the divider load, 16 divider bits and the result register;
// the 16 bits come from the restoring divider, one quotient bit a cycle.
// feed.ready is low in reset and from the last sample until the result is
// registered. A stalled result stays in its register; the next series is
// accepted meanwhile, and only its own finish waits for the register to empty.
// Configuration: cfg_write with cfg_index 0 lag, 1 mean, 2 variance, while
// idle. Reset restores register defaults and clears the run state; the delay
// line is not cleared, since only entries written in the run are read.
// ----------------------------------------------------------------------------
`default_nettype none

module lagged_autocorrelation #(
  parameter int MAX_LAG = 512
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [lac_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lac_pkg::VAR_W-1:0]       cfg_data,
  lac_in_if.sink                          feed,
  lac_out_if.source                       result
);
  import lac_pkg::*;

  logic [LAG_W-1:0]  lag_distance;
  logic [MEAN_W-1:0] mean_value;
  logic [VAR_W-1:0]  variance_value;

  lac_cmd_t  cmd;
  lac_stat_t stat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lag_distance   <= LAG_RESET;
      mean_value     <= MEAN_RESET;
      variance_value <= VAR_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_LAG:  lag_distance   <= cfg_data[LAG_W-1:0];
        REG_MEAN: mean_value     <= cfg_data[MEAN_W-1:0];
        REG_VAR:  variance_value <= cfg_data[VAR_W-1:0];
        default: ;
      endcase
    end
  end

  lac_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .feed_valid (feed.valid),
    .feed_last  (feed.last),
    .feed_ready (feed.ready),
    .res_ready  (result.ready),
    .res_valid  (result.valid),
    .cmd        (cmd),
    .stat       (stat)
  );

  lac_datapath #(
    .MAX_LAG (MAX_LAG)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .lag_distance    (lag_distance),
    .mean_value      (mean_value),
    .variance_value  (variance_value),
    .sample          (feed.sample),
    .autocorrelation (result.autocorrelation),
    .sample_total    (result.sample_total),
    .saturated       (result.saturated)
  );

endmodule

`default_nettype wire
